FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helper macros used by smlv_walker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/smlv_pkg.sv
// ---------------------------------------------------------------------------
// smlv_pkg
// types and constants of the stun message length validator
// ---------------------------------------------------------------------------
package smlv_pkg;

   localparam int CNT_W      = 17;
   localparam int LEN_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] HDR_LEN    = 17'd20;
   localparam logic [CNT_W-1:0] MIN_BYTES  = 17'd4;
   localparam logic [CNT_W-1:0] COUNT_MAX  = 17'h1FFFF;
   localparam logic [CNT_W-1:0] ATTR_ROUND = 17'd3;

   localparam logic [CSR_ADDR_W-1:0] ADDR_PADDING_REQUIRED = 3'd0;

   typedef enum logic [1:0] {
      STATUS_VALID      = 2'd0,
      STATUS_INCOMPLETE = 2'd1,
      STATUS_INVALID    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [CNT_W-1:0]   message_length;
   } rsp_type;

   // handoff from the walker to the output register
   typedef struct packed {
      logic    push;
      rsp_type result;
   } result_push_type;

endpackage

FILE: src/stun_message_length_validator_top.sv
// ---------------------------------------------------------------------------
// stun_message_length_validator_top
// checks the stated length and attribute layout of a received stun datagram
// ---------------------------------------------------------------------------
// usage:
//   req channel carries one datagram byte per word with a last_byte flag.
//   rsp channel gives one word per datagram, on its last byte: status
//   (valid, incomplete, invalid) and the total message length when valid.
//   apb port holds padding_required at address 0 (reset value 1); write it
//   only while no datagram is in flight.
// timing:
//   one byte per cycle while the result register can take a last byte; a byte
//   is held in the input register and its result is loaded from there into
//   the result register, which drives rsp_valid.
//   the rate is set by the combinational header and attribute update.
// reset:
//   synchronous reset empties both registers, clears the walk state and sets
//   padding_required back to 1.
// stall:
//   while rsp is held off, non-final bytes keep flowing; a last byte waits in
//   the input register until the result register frees up.
// ---------------------------------------------------------------------------
module stun_message_length_validator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  smlv_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output smlv_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smlv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [smlv_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [smlv_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic                      padding_required;
   logic                      advance;
   logic                      item_valid;
   smlv_pkg::req_type         item;
   logic                      out_free;
   smlv_pkg::result_push_type push;

   smlv_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .padding_required (padding_required)
   );

   smlv_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   smlv_walker u_walker (
      .clock            (clock),
      .reset            (reset),
      .padding_required (padding_required),
      .item_valid       (item_valid),
      .item             (item),
      .out_free         (out_free),
      .advance          (advance),
      .push             (push)
   );

   smlv_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/smlv_csr.sv
// ---------------------------------------------------------------------------
// smlv_csr
// apb register file: holds the padding_required control bit
// ---------------------------------------------------------------------------
module smlv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smlv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [smlv_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [smlv_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic                                padding_required
);

   logic padding_ff;
   logic padding_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr == smlv_pkg::ADDR_PADDING_REQUIRED);

   always_comb begin
      padding_in = padding_ff;
      if (wr_en) begin
         padding_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         padding_ff <= 1'b1;
      end else begin
         padding_ff <= padding_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == smlv_pkg::ADDR_PADDING_REQUIRED) begin
         prdata[0] = padding_ff;
      end
   end

   assign padding_required = padding_ff;

endmodule

FILE: src/smlv_in_reg.sv
// ---------------------------------------------------------------------------
// smlv_in_reg
// input register stage in front of the byte walker
// ---------------------------------------------------------------------------
module smlv_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smlv_pkg::req_type req_data,
   input  logic              advance,
   output logic              item_valid,
   output smlv_pkg::req_type item
);

   logic              valid_ff;
   logic              valid_in;
   smlv_pkg::req_type item_ff;
   smlv_pkg::req_type item_in;
   logic              take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: src/smlv_walker.sv
// ---------------------------------------------------------------------------
// smlv_walker
// per-byte header and attribute walk, builds the result on the last byte
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smlv_walker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        padding_required,
   input  logic                        item_valid,
   input  smlv_pkg::req_type           item,
   input  logic                        out_free,
   output logic                        advance,
   output smlv_pkg::result_push_type   push
);

   localparam int CW = smlv_pkg::CNT_W;
   localparam int LW = smlv_pkg::LEN_W;

   logic [CW-1:0] byte_count_ff,       byte_count_in;
   logic          first_byte_bad_ff,   first_byte_bad_in;
   logic [LW-1:0] length_field_ff,     length_field_in;
   logic [1:0]    attr_header_index_ff, attr_header_index_in;
   logic [LW-1:0] attr_length_hold_ff, attr_length_hold_in;
   logic [CW-1:0] value_bytes_left_ff, value_bytes_left_in;
   logic          in_value_ff,         in_value_in;
   logic          attr_error_ff,       attr_error_in;

   logic [CW-1:0] pos;
   logic [CW-1:0] count_next;
   logic          first_bad;
   logic [LW-1:0] length_val;
   logic [CW-1:0] mlen;
   logic [CW-1:0] alen;
   logic [CW-1:0] remaining;
   logic          walk_en;
   logic [1:0]    idx_next;
   logic [LW-1:0] hold_next;
   logic [CW-1:0] vbl_next;
   logic          inv_next;
   logic          err_next;
   smlv_pkg::rsp_type result;

   // a last byte needs a free output slot, other bytes never stall
   assign advance = item_valid && (!item.last_byte || out_free);

   always_comb begin
      pos        = byte_count_ff;
      first_bad  = first_byte_bad_ff;
      length_val = length_field_ff;
      if (pos == '0) begin
         first_bad = |item.data_byte[7:6];
      end else if (pos == 17'd2) begin
         length_val = {item.data_byte, 8'h00};
      end else if (pos == 17'd3) begin
         length_val = {length_field_ff[15:8], item.data_byte};
      end
      mlen       = {1'b0, length_val} + smlv_pkg::HDR_LEN;
      count_next = (pos == smlv_pkg::COUNT_MAX) ? pos : pos + 17'd1;

      idx_next  = attr_header_index_ff;
      hold_next = attr_length_hold_ff;
      vbl_next  = value_bytes_left_ff;
      inv_next  = in_value_ff;
      err_next  = attr_error_ff;
      alen      = '0;
      remaining = mlen - count_next;
      walk_en   = (pos >= smlv_pkg::HDR_LEN) && (pos < mlen) && !attr_error_ff;

      if (walk_en) begin
         if (in_value_ff) begin
            vbl_next = value_bytes_left_ff - 17'd1;
            if (vbl_next == '0) begin
               inv_next = 1'b0;
            end
         end else begin
            if (attr_header_index_ff == 2'd2) begin
               hold_next = {item.data_byte, 8'h00};
            end else if (attr_header_index_ff == 2'd3) begin
               hold_next = {attr_length_hold_ff[15:8], item.data_byte};
            end
            if (attr_header_index_ff != 2'd3) begin
               idx_next = attr_header_index_ff + 2'd1;
            end else begin
               idx_next = 2'd0;
               alen     = {1'b0, hold_next};
               // round the value length up to a word
               if (padding_required) begin
                  alen = (alen + smlv_pkg::ATTR_ROUND) & ~smlv_pkg::ATTR_ROUND;
               end
               if (alen > remaining) begin
                  err_next = 1'b1;
               end else if (alen != '0) begin
                  inv_next = 1'b1;
                  vbl_next = alen;
               end
            end
         end
      end
   end

   always_comb begin
      result.message_length = '0;
      if (first_bad) begin
         result.status = smlv_pkg::STATUS_INVALID;
      end else if (count_next < smlv_pkg::MIN_BYTES) begin
         result.status = smlv_pkg::STATUS_INCOMPLETE;
      end else if (padding_required && (mlen[1:0] != 2'b00)) begin
         result.status = smlv_pkg::STATUS_INVALID;
      end else if (count_next < mlen) begin
         result.status = smlv_pkg::STATUS_INCOMPLETE;
      end else if (err_next || (idx_next != 2'd0)) begin
         result.status = smlv_pkg::STATUS_INVALID;
      end else begin
         result.status         = smlv_pkg::STATUS_VALID;
         result.message_length = mlen;
      end
   end

   always_comb begin
      byte_count_in        = byte_count_ff;
      first_byte_bad_in    = first_byte_bad_ff;
      length_field_in      = length_field_ff;
      attr_header_index_in = attr_header_index_ff;
      attr_length_hold_in  = attr_length_hold_ff;
      value_bytes_left_in  = value_bytes_left_ff;
      in_value_in          = in_value_ff;
      attr_error_in        = attr_error_ff;
      if (advance) begin
         if (item.last_byte) begin
            byte_count_in        = '0;
            first_byte_bad_in    = 1'b0;
            length_field_in      = '0;
            attr_header_index_in = 2'd0;
            attr_length_hold_in  = '0;
            value_bytes_left_in  = '0;
            in_value_in          = 1'b0;
            attr_error_in        = 1'b0;
         end else begin
            byte_count_in        = count_next;
            first_byte_bad_in    = first_bad;
            length_field_in      = length_val;
            attr_header_index_in = idx_next;
            attr_length_hold_in  = hold_next;
            value_bytes_left_in  = vbl_next;
            in_value_in          = inv_next;
            attr_error_in        = err_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff        <= '0;
         first_byte_bad_ff    <= 1'b0;
         length_field_ff      <= '0;
         attr_header_index_ff <= 2'd0;
         attr_length_hold_ff  <= '0;
         value_bytes_left_ff  <= '0;
         in_value_ff          <= 1'b0;
         attr_error_ff        <= 1'b0;
      end else begin
         byte_count_ff        <= byte_count_in;
         first_byte_bad_ff    <= first_byte_bad_in;
         length_field_ff      <= length_field_in;
         attr_header_index_ff <= attr_header_index_in;
         attr_length_hold_ff  <= attr_length_hold_in;
         value_bytes_left_ff  <= value_bytes_left_in;
         in_value_ff          <= in_value_in;
         attr_error_ff        <= attr_error_in;
      end
   end

   assign push.push   = advance && item.last_byte;
   assign push.result = result;

   `ASSERT_IMPL(a_valid_len_min, clock, reset,
      push.push && (result.status == smlv_pkg::STATUS_VALID),
      result.message_length >= smlv_pkg::HDR_LEN)
   `ASSERT_IMPL(a_bad_len_zero, clock, reset,
      push.push && (result.status != smlv_pkg::STATUS_VALID),
      result.message_length == '0)
   `ASSERT_NEXT(a_clear_after_last, clock, reset,
      push.push,
      (byte_count_ff == '0) && !in_value_ff && !attr_error_ff)
   `ASSERT_IMPL(a_value_count_live, clock, reset,
      in_value_ff,
      value_bytes_left_ff != '0)

endmodule

FILE: src/smlv_out_reg.sv
// ---------------------------------------------------------------------------
// smlv_out_reg
// result register driving the response channel
// ---------------------------------------------------------------------------
module smlv_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  smlv_pkg::result_push_type push,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output smlv_pkg::rsp_type         rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   smlv_pkg::rsp_type data_ff;
   smlv_pkg::rsp_type data_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push.push) begin
         valid_in = 1'b1;
         data_in  = push.result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
